// ----- src/bitmap_page_allocator_core_defines.svh -----
// Assertion macros for the bitmap page allocator.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- src/bpa_pkg.sv -----
// Shared types and constants of the bitmap page allocator.
// No dependencies.
package bpa_pkg;

	localparam int RUN_W = 7;

	localparam logic [31:0] HEAP_VBASE = 32'hC010_0000;
	localparam logic [31:0] FRAME_BASE = 32'h0020_0000;
	localparam int          RESERVED_PAGES = 512;

	// RAM half select
	localparam logic MAP_VIRT  = 1'b0;
	localparam logic MAP_FRAME = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_VIRT   = 3'd1,
		ST_NO_FRAME  = 3'd2,
		ST_BAD_COUNT = 3'd3,
		ST_USER      = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_VRD,
		FSM_VEV,
		FSM_MRD,
		FSM_MWR,
		FSM_FRD,
		FSM_FEV,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic [31:0]      virt_addr;
		logic [31:0]      phys_addr;
		logic             new_table;
		logic [31:0]      table_addr;
		status_t          status;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      data;
		logic [5:0]       lim;     // number of in-pool bits in this word
		logic [RUN_W-1:0] run_in;
		logic [RUN_W-1:0] cnt;
	} scan_req_t;

	typedef struct packed {
		logic             hit;
		logic [4:0]       pos;     // bit where the run reaches cnt
		logic [RUN_W-1:0] run_out;
		logic             full;
	} scan_res_t;

endpackage

// ----- src/bpa_cfg_if.sv -----
// Configuration write channel: total memory size in pages.
// No dependencies.
interface bpa_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/bpa_req_if.sv -----
// Request channel: pool select and page count.
// No dependencies.
interface bpa_req_if;
	logic        valid;
	logic        ready;
	logic        pool_sel;
	logic [11:0] page_count;

	modport source (output valid, output pool_sel, output page_count, input ready);
	modport sink (input valid, input pool_sel, input page_count, output ready);
endinterface

// ----- src/bpa_rsp_if.sv -----
// Result channel: one transfer per allocated page or per failure.
// No dependencies.
interface bpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic        new_table;
	logic [31:0] table_addr;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, output virt_addr, output phys_addr, output new_table,
		output table_addr, output status, output last, input ready);
	modport sink (input valid, input virt_addr, input phys_addr, input new_table,
		input table_addr, input status, input last, output ready);
endinterface

// ----- src/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/bpa_scan.sv -----
// Word scan unit: finds where a run of free bits reaches the wanted length.
// Depends on bpa_pkg.
module bpa_scan (
	input  bpa_pkg::scan_req_t sreq,
	output bpa_pkg::scan_res_t sres
);

	logic [31:0] busy;
	logic [31:0] hit_v;
	logic [4:0]  hb;
	logic        any_busy;
	logic [4:0]  pos;

	always_comb begin
		int  c;
		int  lo;
		logic clear_win;
		c = int'(sreq.cnt);
		for (int b = 0; b < 32; b++) begin
			busy[b] = sreq.data[b] | (b >= int'(sreq.lim));
		end
		for (int p = 0; p < 32; p++) begin
			lo = (p + 1 >= c) ? (p + 1 - c) : 0;
			clear_win = 1'b1;
			for (int b = 0; b < 32; b++) begin
				if (b >= lo && b <= p && busy[b]) begin
					clear_win = 1'b0;
				end
			end
			if (p + 1 >= c) begin
				hit_v[p] = clear_win;
			end else begin
				// run must continue from the previous word
				hit_v[p] = clear_win && (int'(sreq.run_in) >= c - p - 1);
			end
		end
	end

	always_comb begin
		pos = 5'd0;
		for (int p = 31; p >= 0; p--) begin
			if (hit_v[p]) begin
				pos = 5'(p);
			end
		end
		hb = 5'd0;
		any_busy = 1'b0;
		for (int b = 0; b < 32; b++) begin
			if (busy[b]) begin
				hb = 5'(b);
				any_busy = 1'b1;
			end
		end
	end

	always_comb begin
		sres.hit  = |hit_v;
		sres.pos  = pos;
		sres.full = &sreq.data;
		// only meaningful without a hit, where it stays below cnt
		sres.run_out = any_busy ? bpa_pkg::RUN_W'(5'd31 - hb)
			: bpa_pkg::RUN_W'(sreq.run_in + bpa_pkg::RUN_W'(32));
	end

endmodule

// ----- src/bitmap_page_allocator_core.sv -----
// Bitmap page allocator top level: sequencer, bitmap RAM and directory bits.
// Depends on bpa_pkg, bpa_*_if, bpa_ram, bpa_scan and the defines header.
//
// After reset the block clears both bitmaps, one RAM word a cycle, before
// the first request is taken; configuration writes are taken at any time. A
// bad count or user pool request passes its single result from res_q to the
// output register. A kernel request reads and evaluates bitmap words for the
// virtual run, starting at the virtual hint below which all words are known
// full, then reads and writes back each word of the run to mark it (at most
// three), then for each page scans the frame bitmap from the frame hint,
// continues the scan for a page table frame when the directory slot is not
// yet present, and hands over the result. All of this runs through one
// word-wide scan unit and the single read port of the bitmap RAM. A result
// waits in an output register, and the next request is taken while the last
// result of the previous one waits.
`include "bitmap_page_allocator_core_defines.svh"

module bitmap_page_allocator_core #(
	parameter int POOL_PAGES = 16384,
	parameter int MAX_RUN    = 64
) (
	input logic        clk,
	input logic        arst_n,
	bpa_cfg_if.sink    cfg,
	bpa_req_if.sink    req,
	bpa_rsp_if.source  rsp
);

	localparam int MAP_WORDS = (POOL_PAGES + 31) / 32;
	localparam int WW        = $clog2(MAP_WORDS);
	localparam int AW        = WW + 1;
	localparam int IDX_W     = WW + 5;
	localparam int LEN_W     = $clog2(POOL_PAGES + 1);
	localparam int CW        = LEN_W + 2;
	localparam int DIR_SLOTS = (MAP_WORDS * 32 + 256 + 1023) / 1024;
	localparam int DIR_W     = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
	localparam int RW        = bpa_pkg::RUN_W;

	bpa_pkg::fsm_t      state_q, state_d;
	logic [15:0]        cfg_q;
	logic [AW-1:0]      clr_q;
	logic [WW:0]        vhint_q, fhint_q;
	logic [DIR_SLOTS-1:0] dir_q;
	logic               out_vld_q;
	bpa_pkg::rsp_t      out_q;

	logic [LEN_W-1:0]   len_q;
	logic [RW-1:0]      cnt_q, run_q, pg_q;
	logic [WW:0]        w_q;
	logic [IDX_W-1:0]   start_q, vidx_q;
	logic               tbl_q;
	logic [31:0]        pa_q;
	bpa_pkg::rsp_t      res_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;

	bpa_pkg::scan_req_t sreq;
	bpa_pkg::scan_res_t sres;

	// ---- pool length from the memory size
	logic [15:0]        free_pages, k_pages;
	logic [LEN_W-1:0]   len_now;

	always_comb begin
		free_pages = (cfg_q >= 16'(bpa_pkg::RESERVED_PAGES))
			? cfg_q - 16'(bpa_pkg::RESERVED_PAGES) : 16'd0;
		k_pages = {1'b0, free_pages[15:1]} & ~16'h0007;
		len_now = (32'(k_pages) > POOL_PAGES) ? LEN_W'(POOL_PAGES) : LEN_W'(k_pages);
	end

	// ---- word bookkeeping
	logic [CW-1:0]      nwords, rem;
	logic               w_ok;
	logic [5:0]         lim;
	logic [WW-1:0]      word;

	assign word   = w_q[WW-1:0];
	assign nwords = (CW'(len_q) + CW'(31)) >> 5;
	assign w_ok   = CW'(w_q) < nwords;
	assign rem    = CW'(len_q) - (CW'(w_q) << 5);
	assign lim    = (rem >= CW'(32)) ? 6'd32 : rem[5:0];

	logic [IDX_W:0]     start_sum;
	logic [IDX_W-1:0]   start_now, end_idx, fidx, bit_idx;
	logic [WW-1:0]      end_word;
	logic [31:0]        mark_mask, frame_bit, faddr, va;
	logic [IDX_W:0]     dir_sum;
	logic [DIR_W-1:0]   dir_idx;
	logic               dir_hit, last_pg;

	always_comb begin
		start_sum = {1'b0, word, sres.pos} + (IDX_W + 1)'(1) - (IDX_W + 1)'(cnt_q);
		start_now = start_sum[IDX_W-1:0];
		end_idx   = start_q + IDX_W'(cnt_q) - IDX_W'(1);
		end_word  = end_idx[IDX_W-1:5];
		for (int b = 0; b < 32; b++) begin
			bit_idx = {word, 5'(b)};
			mark_mask[b] = (bit_idx >= start_q) && (bit_idx <= end_idx);
		end
		frame_bit = 32'd1 << sres.pos;
		fidx      = {word, sres.pos};
		faddr     = bpa_pkg::FRAME_BASE + (32'(fidx) << 12);
		va        = bpa_pkg::HEAP_VBASE + (32'(vidx_q) << 12);
		dir_sum   = (IDX_W + 1)'(vidx_q) + (IDX_W + 1)'(256);
		dir_idx   = DIR_W'(dir_sum >> 10);
		dir_hit   = dir_q[dir_idx];
		last_pg   = (pg_q == cnt_q - RW'(1));
	end

	logic req_xfer, bad_cnt, can_load;
	bpa_pkg::status_t early_st;

	assign req_xfer = req.valid && req.ready;
	assign bad_cnt  = (req.page_count == 12'd0) || (32'(req.page_count) > MAX_RUN);
	assign can_load = (state_q == bpa_pkg::FSM_EMIT) && (!out_vld_q || rsp.ready);

	// bad count wins over the user pool
	always_comb begin
		if (bad_cnt) early_st = bpa_pkg::ST_BAD_COUNT;
		else if (req.pool_sel) early_st = bpa_pkg::ST_USER;
		else early_st = bpa_pkg::ST_OK;
	end

	// ---- shared scan unit
	always_comb begin
		sreq.data = ram_rdata;
		sreq.lim  = lim;
		if (state_q == bpa_pkg::FSM_VEV) begin
			sreq.run_in = run_q;
			sreq.cnt    = cnt_q;
		end else begin
			sreq.run_in = RW'(0);
			sreq.cnt    = RW'(1);
		end
	end

	bpa_scan u_scan (
		.sreq (sreq),
		.sres (sres)
	);

	bpa_ram #(
		.WIDTH (32),
		.DEPTH (2 ** AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::FSM_CLEAR: begin
				if (clr_q == '1) state_d = bpa_pkg::FSM_IDLE;
			end
			bpa_pkg::FSM_IDLE: begin
				if (req_xfer) begin
					state_d = (bad_cnt || req.pool_sel) ? bpa_pkg::FSM_EMIT : bpa_pkg::FSM_VRD;
				end
			end
			bpa_pkg::FSM_VRD: state_d = w_ok ? bpa_pkg::FSM_VEV : bpa_pkg::FSM_EMIT;
			bpa_pkg::FSM_VEV: state_d = sres.hit ? bpa_pkg::FSM_MRD : bpa_pkg::FSM_VRD;
			bpa_pkg::FSM_MRD: state_d = bpa_pkg::FSM_MWR;
			bpa_pkg::FSM_MWR: begin
				state_d = (word == end_word) ? bpa_pkg::FSM_FRD : bpa_pkg::FSM_MRD;
			end
			bpa_pkg::FSM_FRD: state_d = w_ok ? bpa_pkg::FSM_FEV : bpa_pkg::FSM_EMIT;
			bpa_pkg::FSM_FEV: begin
				if (sres.hit && (tbl_q || dir_hit)) state_d = bpa_pkg::FSM_EMIT;
				else state_d = bpa_pkg::FSM_FRD;
			end
			bpa_pkg::FSM_EMIT: begin
				if (can_load) state_d = res_q.last ? bpa_pkg::FSM_IDLE : bpa_pkg::FSM_FRD;
			end
			default: state_d = bpa_pkg::FSM_IDLE;
		endcase
	end

	// ---- outputs: RAM control and handshakes
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			bpa_pkg::FSM_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			bpa_pkg::FSM_VRD, bpa_pkg::FSM_MRD: ram_raddr = {bpa_pkg::MAP_VIRT, word};
			bpa_pkg::FSM_FRD: ram_raddr = {bpa_pkg::MAP_FRAME, word};
			bpa_pkg::FSM_MWR: begin
				ram_we    = 1'b1;
				ram_waddr = {bpa_pkg::MAP_VIRT, word};
				ram_wdata = ram_rdata | mark_mask;
			end
			bpa_pkg::FSM_FEV: begin
				ram_we    = sres.hit;
				ram_waddr = {bpa_pkg::MAP_FRAME, word};
				ram_wdata = ram_rdata | frame_bit;
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == bpa_pkg::FSM_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid      = out_vld_q;
	assign rsp.virt_addr  = out_q.virt_addr;
	assign rsp.phys_addr  = out_q.phys_addr;
	assign rsp.new_table  = out_q.new_table;
	assign rsp.table_addr = out_q.table_addr;
	assign rsp.status     = out_q.status;
	assign rsp.last       = out_q.last;

	// ---- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bpa_pkg::FSM_CLEAR;
			cfg_q     <= 16'd8192;
			clr_q     <= '0;
			vhint_q   <= '0;
			fhint_q   <= '0;
			dir_q     <= DIR_SLOTS'(1);
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) cfg_q <= cfg.data;
			if (state_q == bpa_pkg::FSM_CLEAR) clr_q <= clr_q + AW'(1);
			// words below a hint are known full; bits are never released
			if (state_q == bpa_pkg::FSM_VEV && !sres.hit && sres.full && w_q == vhint_q) begin
				vhint_q <= vhint_q + (WW + 1)'(1);
			end
			if (state_q == bpa_pkg::FSM_FEV && w_q == fhint_q
				&& (sres.hit ? &(ram_rdata | frame_bit) : sres.full)) begin
				fhint_q <= fhint_q + (WW + 1)'(1);
			end
			if (state_q == bpa_pkg::FSM_FEV && sres.hit && tbl_q) dir_q[dir_idx] <= 1'b1;
			if (can_load) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	// ---- datapath registers
	always_ff @(posedge clk) begin
		if (can_load) out_q <= res_q;
		case (state_q)
			bpa_pkg::FSM_IDLE: begin
				if (req_xfer) begin
					cnt_q <= RW'(req.page_count);
					len_q <= len_now;
					w_q   <= vhint_q;
					run_q <= RW'(0);
					res_q <= '{virt_addr: 32'd0, phys_addr: 32'd0, new_table: 1'b0,
						table_addr: 32'd0, status: early_st, last: 1'b1};
				end
			end
			bpa_pkg::FSM_VRD: begin
				if (!w_ok) begin
					res_q <= '{virt_addr: 32'd0, phys_addr: 32'd0, new_table: 1'b0,
						table_addr: 32'd0, status: bpa_pkg::ST_NO_VIRT, last: 1'b1};
				end
			end
			bpa_pkg::FSM_VEV: begin
				if (sres.hit) begin
					start_q <= start_now;
					w_q     <= (WW + 1)'(start_now[IDX_W-1:5]);
				end else begin
					w_q   <= w_q + (WW + 1)'(1);
					run_q <= sres.run_out;
				end
			end
			bpa_pkg::FSM_MWR: begin
				if (word == end_word) begin
					vidx_q <= start_q;
					pg_q   <= RW'(0);
					tbl_q  <= 1'b0;
					w_q    <= fhint_q;
				end else begin
					w_q <= w_q + (WW + 1)'(1);
				end
			end
			bpa_pkg::FSM_FRD: begin
				if (!w_ok) begin
					res_q.virt_addr  <= va;
					res_q.phys_addr  <= tbl_q ? pa_q : 32'd0;
					res_q.new_table  <= 1'b0;
					res_q.table_addr <= 32'd0;
					res_q.status     <= bpa_pkg::ST_NO_FRAME;
					res_q.last       <= 1'b1;
				end
			end
			bpa_pkg::FSM_FEV: begin
				if (sres.hit) begin
					res_q.virt_addr <= va;
					res_q.status    <= bpa_pkg::ST_OK;
					res_q.last      <= last_pg;
					if (!tbl_q) begin
						pa_q             <= faddr;
						res_q.phys_addr  <= faddr;
						res_q.new_table  <= 1'b0;
						res_q.table_addr <= 32'd0;
						if (!dir_hit) tbl_q <= 1'b1;
					end else begin
						res_q.phys_addr  <= pa_q;
						res_q.new_table  <= 1'b1;
						res_q.table_addr <= faddr;
					end
				end else begin
					w_q <= w_q + (WW + 1)'(1);
				end
			end
			bpa_pkg::FSM_EMIT: begin
				if (can_load && !res_q.last) begin
					vidx_q <= vidx_q + IDX_W'(1);
					pg_q   <= pg_q + RW'(1);
					tbl_q  <= 1'b0;
					w_q    <= fhint_q;
				end
			end
			default: ;
		endcase
	end

	`BPA_ASSERT_IMP(a_err_is_last, rsp.valid && (rsp.status != 3'(bpa_pkg::ST_OK)), rsp.last, "error result not last")
	`BPA_ASSERT_IMP(a_table_ok, rsp.valid && rsp.new_table, (rsp.status == 3'(bpa_pkg::ST_OK)) && (rsp.table_addr != 32'd0), "new table on failed result")
	`BPA_ASSERT_NXT(a_vhint_mono, 1'b1, vhint_q >= $past(vhint_q), "virtual hint moved back")
	`BPA_ASSERT_NXT(a_fhint_mono, 1'b1, fhint_q >= $past(fhint_q), "frame hint moved back")
	`BPA_ASSERT_IMP(a_kernel_dir, 1'b1, dir_q[0], "kernel directory slot lost")

endmodule

// ----- dv/tb_bitmap_page_allocator_core.sv -----
// Self-checking testbench for bitmap_page_allocator_core: predicts the results of
// each request and checks them against the result channel.
// Depends on bpa_pkg, bpa_cfg_if, bpa_req_if, bpa_rsp_if and the core.
`timescale 1ns / 100ps

module tb_bitmap_page_allocator_core;

	localparam int POOL_PAGES = 16384;
	localparam int MAX_RUN    = 64;
	localparam int PAGE_BYTES = 4096;
	localparam int KERNEL_DIR_SLOT = 768;

	typedef struct {
		logic        sel;
		logic [11:0] cnt;
	} alloc_req_t;

	logic clk;
	logic arst_n;

	bpa_cfg_if cfg_ch();
	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();

	bitmap_page_allocator_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// predictor state
	bit          page_map [2][POOL_PAGES];
	bit          dir_present [1024];
	logic [15:0] mem_pages;

	alloc_req_t     pending_q [$];
	bpa_pkg::rsp_t  expected_q [$];
	int             idle_mode;
	int             mismatches;
	bit             req_taken;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic int kernel_len();
		int free_pages;
		int k;
		free_pages = (int'(mem_pages) >= bpa_pkg::RESERVED_PAGES)
			? (int'(mem_pages) - bpa_pkg::RESERVED_PAGES) : 0;
		k = (free_pages / 2) / 8 * 8;
		if (k > POOL_PAGES)
			k = POOL_PAGES;
		return k;
	endfunction

	// first-fit search for cnt clear bits below len
	function automatic bit find_free_run(int which, int len, int cnt, output int at);
		int run;
		run = 0;
		at = 0;
		for (int i = 0; i < len; i++) begin
			if (page_map[which][i]) begin
				run = 0;
			end else begin
				run++;
				if (run == cnt) begin
					at = i + 1 - cnt;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic void push_result(logic [31:0] va, logic [31:0] pa, logic nt,
			logic [31:0] ta, bpa_pkg::status_t st, logic last);
		bpa_pkg::rsp_t r;
		r.virt_addr  = va;
		r.phys_addr  = pa;
		r.new_table  = nt;
		r.table_addr = ta;
		r.status     = st;
		r.last       = last;
		expected_q.push_back(r);
	endfunction

	function automatic void predict_alloc(alloc_req_t it);
		int          len;
		int          start;
		int          fidx;
		int          tidx;
		int          slot;
		int          cnt;
		logic [31:0] va;
		logic [31:0] pa;
		logic [31:0] ta;
		logic        nt;
		cnt = int'(it.cnt);
		if (cnt == 0 || cnt > MAX_RUN) begin
			push_result(32'd0, 32'd0, 1'b0, 32'd0, bpa_pkg::ST_BAD_COUNT, 1'b1);
			return;
		end
		if (it.sel) begin
			push_result(32'd0, 32'd0, 1'b0, 32'd0, bpa_pkg::ST_USER, 1'b1);
			return;
		end
		len = kernel_len();
		if (!find_free_run(int'(bpa_pkg::MAP_VIRT), len, cnt, start)) begin
			push_result(32'd0, 32'd0, 1'b0, 32'd0, bpa_pkg::ST_NO_VIRT, 1'b1);
			return;
		end
		for (int i = 0; i < cnt; i++)
			page_map[int'(bpa_pkg::MAP_VIRT)][start + i] = 1'b1;
		for (int i = 0; i < cnt; i++) begin
			va = bpa_pkg::HEAP_VBASE + 32'((start + i) * PAGE_BYTES);
			slot = int'(va[31:22]);
			ta = '0;
			nt = 1'b0;
			if (!find_free_run(int'(bpa_pkg::MAP_FRAME), len, 1, fidx)) begin
				push_result(va, 32'd0, 1'b0, 32'd0, bpa_pkg::ST_NO_FRAME, 1'b1);
				return;
			end
			page_map[int'(bpa_pkg::MAP_FRAME)][fidx] = 1'b1;
			pa = bpa_pkg::FRAME_BASE + 32'(fidx * PAGE_BYTES);
			if (!dir_present[slot]) begin
				if (!find_free_run(int'(bpa_pkg::MAP_FRAME), len, 1, tidx)) begin
					push_result(va, pa, 1'b0, 32'd0, bpa_pkg::ST_NO_FRAME, 1'b1);
					return;
				end
				page_map[int'(bpa_pkg::MAP_FRAME)][tidx] = 1'b1;
				ta = bpa_pkg::FRAME_BASE + 32'(tidx * PAGE_BYTES);
				dir_present[slot] = 1'b1;
				nt = 1'b1;
			end
			push_result(va, pa, nt, ta, bpa_pkg::ST_OK, (i + 1 == cnt));
		end
	endfunction

	// request driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.pool_sel   <= 1'b0;
			req_ch.page_count <= '0;
		end else if (!(req_ch.valid && !req_taken)) begin
			if (pending_q.size() > 0 &&
					!((idle_mode == 1 && $urandom_range(99) < 87) ||
					(idle_mode == 3 && $urandom_range(99) < 26))) begin
				req_ch.valid      <= 1'b1;
				req_ch.pool_sel   <= pending_q[0].sel;
				req_ch.page_count <= pending_q[0].cnt;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// result receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !((idle_mode == 2 && $urandom_range(99) < 87) ||
				(idle_mode == 3 && $urandom_range(99) < 26));
		end
	end

	// monitor: request transfers feed the predictor, result transfers are checked
	always @(posedge clk) begin
		bpa_pkg::rsp_t got;
		bpa_pkg::rsp_t want;
		if (arst_n && req_ch.valid && req_ch.ready && pending_q.size() > 0) begin
			predict_alloc(pending_q.pop_front());
			req_taken = 1'b1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.virt_addr  = rsp_ch.virt_addr;
			got.phys_addr  = rsp_ch.phys_addr;
			got.new_table  = rsp_ch.new_table;
			got.table_addr = rsp_ch.table_addr;
			got.status     = bpa_pkg::status_t'(rsp_ch.status);
			got.last       = rsp_ch.last;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	task automatic write_mem_pages(logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		mem_pages = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic add_req(logic sel, logic [11:0] cnt);
		alloc_req_t it;
		it.sel = sel;
		it.cnt = cnt;
		pending_q.push_back(it);
	endtask

	task automatic add_random_reqs(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8)
				add_req(1'($urandom_range(1)), ($urandom_range(1) != 0) ? 12'd0
					: 12'($urandom_range(4095, MAX_RUN + 1)));
			else if (r < 14)
				add_req(1'b1, 12'($urandom_range(MAX_RUN, 1)));
			else if (r < 80)
				add_req(1'b0, 12'($urandom_range(16, 1)));
			else
				add_req(1'b0, 12'($urandom_range(MAX_RUN, 1)));
		end
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && expected_q.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic run_phase(logic [15:0] mem, int mode, int n);
		write_mem_pages(mem);
		idle_mode = mode;
		add_random_reqs(n);
		drain();
	endtask

	initial begin
		mismatches = 0;
		idle_mode = 0;
		req_taken = 1'b0;
		mem_pages = 16'd8192;
		dir_present[KERNEL_DIR_SLOT] = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: count limits, user pool, precedence of bad count
		add_req(1'b0, 12'd0);
		add_req(1'b0, 12'd4095);
		add_req(1'b0, 12'd65);
		add_req(1'b0, 12'd2048);
		add_req(1'b1, 12'd0);
		add_req(1'b1, 12'd4095);
		add_req(1'b1, 12'd1);
		add_req(1'b1, 12'd64);
		add_req(1'b0, 12'd64);
		add_req(1'b0, 12'd1);
		for (int b = 1; b < 64; b = b * 2)
			add_req(1'b0, 12'(b));
		add_req(1'b0, 12'd63);
		drain();

		run_phase(16'd1024, 3, 60);   // small pool: runs out of frames and pages
		run_phase(16'd512, 2, 20);    // empty pool
		run_phase(16'd600, 0, 25);
		run_phase(16'd33280, 1, 70);
		run_phase(16'd8192, 2, 70);
		idle_mode = 0;
		repeat (50) @(posedge clk);

		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_bitmap_page_allocator_core: PASS");
		else
			$display("tb_bitmap_page_allocator_core: FAIL");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb_bitmap_page_allocator_core: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/bpa_pkg.sv
src/bpa_cfg_if.sv
src/bpa_req_if.sv
src/bpa_rsp_if.sv
src/bpa_ram.sv
src/bpa_scan.sv
src/bitmap_page_allocator_core.sv
dv/tb_bitmap_page_allocator_core.sv
